FILE: hdl/wbps_pkg.sv
package wbps_pkg;

	localparam int PatternMax = 32;
	localparam int PatternWidth = (PatternMax > 32) ? 32 : PatternMax;
	localparam int OffsetBits = 32;
	localparam int OffsetWidth = (OffsetBits > 32) ? 32 : OffsetBits;

	localparam int CfgDataWidth = 64;
	localparam int CfgAddrWidth = 6;
	localparam int LenWidth = 6;

	typedef enum logic [2:0] {
		REG_PAT_LOW    = 3'd0,
		REG_PAT_SECOND = 3'd1,
		REG_PAT_THIRD  = 3'd2,
		REG_PAT_HIGH   = 3'd3,
		REG_WILDCARD   = 3'd4,
		REG_LENGTH     = 3'd5,
		REG_MODE       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [3:0][63:0]         pattern;
		logic [31:0]              wild_mask;
		logic [LenWidth-1:0]      length;
		logic                     first_only;
	} cfg_t;

	typedef struct packed {
		logic valid_s1;
	} scan_status_t;

endpackage

FILE: hdl/wbps_byte_if.sv
interface wbps_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       region_first;

	modport source (output valid, output data_byte, output region_first, input ready);
	modport sink (input valid, input data_byte, input region_first, output ready);
endinterface

FILE: hdl/wbps_match_if.sv
interface wbps_match_if;
	logic        valid;
	logic        ready;
	logic [31:0] match_offset;

	modport source (output valid, output match_offset, input ready);
	modport sink (input valid, input match_offset, output ready);
endinterface

FILE: hdl/wildcard_byte_pattern_scan.sv
// Scans a byte stream for a signature of up to 32 bytes, any of which may be
// a wildcard, and returns the region offset of the first byte of each match
// (overlaps included; only the first match per region in first-only mode).
// One byte is taken per cycle, back to back, unless a held result word stalls
// the stream; a byte is held in the input register and its match word in the
// result register, with the combinational shift-and update between them. Program the signature
// over the register port only while no bytes are in flight.
module wildcard_byte_pattern_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	wbps_byte_if.sink                        stream,
	wbps_match_if.source                     result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wbps_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [wbps_pkg::CfgDataWidth-1:0] pwdata,
	output logic [wbps_pkg::CfgDataWidth-1:0] prdata,
	output logic                             pready
);

	wbps_pkg::cfg_t cfg;
	wbps_pkg::scan_status_t status;

	wbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wbps_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stream (stream),
		.result (result),
		.status (status)
	);

	// an empty result register never holds the stream off
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> stream.ready)
		else $error("stream stalled with empty result register");

	// a new result word only comes from a byte held in the input stage
	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(status.valid_s1))
		else $error("result word without a byte in flight");

	// every byte taken lands in the input stage next cycle
	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.ready) |=> status.valid_s1)
		else $error("accepted byte lost from input stage");

endmodule

FILE: hdl/wbps_cfg.sv
module wbps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [wbps_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [wbps_pkg::CfgDataWidth-1:0] pwdata,
	output logic [wbps_pkg::CfgDataWidth-1:0] prdata,
	output logic                             pready,
	output wbps_pkg::cfg_t                   cfg
);

	wbps_pkg::cfg_t cfg_q;
	wbps_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = wbps_pkg::reg_idx_t'(paddr[wbps_pkg::CfgAddrWidth-1:3]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.wild_mask <= '0;
			cfg_q.length <= wbps_pkg::LenWidth'(1);
			cfg_q.first_only <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				wbps_pkg::REG_PAT_LOW:    cfg_q.pattern[0] <= pwdata;
				wbps_pkg::REG_PAT_SECOND: cfg_q.pattern[1] <= pwdata;
				wbps_pkg::REG_PAT_THIRD:  cfg_q.pattern[2] <= pwdata;
				wbps_pkg::REG_PAT_HIGH:   cfg_q.pattern[3] <= pwdata;
				wbps_pkg::REG_WILDCARD:   cfg_q.wild_mask <= pwdata[31:0];
				wbps_pkg::REG_LENGTH:     cfg_q.length <= pwdata[wbps_pkg::LenWidth-1:0];
				wbps_pkg::REG_MODE:       cfg_q.first_only <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			wbps_pkg::REG_PAT_LOW:    prdata = cfg_q.pattern[0];
			wbps_pkg::REG_PAT_SECOND: prdata = cfg_q.pattern[1];
			wbps_pkg::REG_PAT_THIRD:  prdata = cfg_q.pattern[2];
			wbps_pkg::REG_PAT_HIGH:   prdata = cfg_q.pattern[3];
			wbps_pkg::REG_WILDCARD:   prdata = {32'd0, cfg_q.wild_mask};
			wbps_pkg::REG_LENGTH:     prdata = {58'd0, cfg_q.length};
			wbps_pkg::REG_MODE:       prdata = {63'd0, cfg_q.first_only};
			default:                  prdata = '0;
		endcase
	end

endmodule

FILE: hdl/wbps_scan.sv
module wbps_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wbps_pkg::cfg_t             cfg,
	wbps_byte_if.sink                  stream,
	wbps_match_if.source               result,
	output wbps_pkg::scan_status_t     status
);

	localparam int PW = wbps_pkg::PatternWidth;
	localparam int OW = wbps_pkg::OffsetWidth;
	localparam int LW = wbps_pkg::LenWidth;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// scan state
	logic [PW-1:0] partial_q;
	logic [OW-1:0] offset_q;
	logic          seen_q;

	// result register
	logic        out_valid_q;
	logic [31:0] out_offset_q;

	logic          go_s1;
	logic [LW-1:0] n;
	logic [PW-1:0] accept;
	logic [PW-1:0] partial_base;
	logic [PW-1:0] partial_next;
	logic [OW-1:0] pos;
	logic          seen_base;
	logic          in_range;
	logic          top_hit;
	logic          hit;
	logic [31:0]   hit_offset;
	logic [7:0]    sig_byte;

	assign go_s1 = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || go_s1;
	assign result.valid = out_valid_q;
	assign result.match_offset = out_offset_q;
	assign status.valid_s1 = valid_s1;

	always_comb begin
		sig_byte = '0;
		n = (cfg.length > LW'(PW)) ? LW'(PW) : cfg.length;
		for (int i = 0; i < PW; i++) begin
			sig_byte = cfg.pattern[i / 8][(i % 8) * 8 +: 8];
			accept[i] = (cfg.wild_mask[i] || (sig_byte == byte_s1)) && (LW'(i) < n);
		end
		partial_base = first_s1 ? '0 : partial_q;
		pos = first_s1 ? '0 : offset_q;
		seen_base = first_s1 ? 1'b0 : seen_q;
		in_range = (pos != {OW{1'b1}});
		partial_next = ((partial_base << 1) | PW'(1)) & accept;
		top_hit = (n != '0) && partial_next[$clog2(PW)'(n - LW'(1))];
		hit = top_hit && in_range && !(cfg.first_only && seen_base);
		hit_offset = 32'(pos) - (32'(n) - 32'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data_byte;
			first_s1 <= stream.region_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			offset_q <= '0;
			seen_q <= 1'b0;
		end else if (go_s1) begin
			partial_q <= partial_next;
			offset_q <= in_range ? pos + OW'(1) : pos;
			seen_q <= seen_base || hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= hit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && hit) begin
			out_offset_q <= hit_offset;
		end
	end

endmodule

FILE: bench/tb_wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scan;

	localparam int unsigned RegUnused = 7;
	localparam logic [31:0] OffsetLimit = (wbps_pkg::OffsetBits >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << wbps_pkg::OffsetBits) - 64'd1);

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [wbps_pkg::CfgAddrWidth-1:0] paddr;
	logic [wbps_pkg::CfgDataWidth-1:0] pwdata;
	logic [wbps_pkg::CfgDataWidth-1:0] prdata;
	logic pready;

	wbps_byte_if byte_ch();
	wbps_match_if match_ch();

	wildcard_byte_pattern_scan uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(byte_ch),
		.result(match_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// register mirror
	logic [3:0][63:0] sig_bytes_cfg;
	logic [31:0] wild_cfg;
	logic [wbps_pkg::LenWidth-1:0] len_cfg;
	logic first_only_cfg;

	// scanner state mirror
	logic [31:0] partial_vec;
	logic [31:0] region_offset;
	logic match_reported;

	logic [31:0] expected_offsets[$];
	int mismatch_count = 0;
	int hold_request = 0;
	bit sender_gaps;
	bit result_stalls;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned active_len();
		return (len_cfg > wbps_pkg::PatternWidth) ? wbps_pkg::PatternWidth : len_cfg;
	endfunction

	function automatic logic [7:0] sig_byte_at(int unsigned i);
		return sig_bytes_cfg[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
	endfunction

	// shift-and update for one accepted byte, queues the match offset if one is due
	function automatic void scan_byte(logic [7:0] b, logic first);
		int unsigned n;
		logic [31:0] accept;
		logic [31:0] pos;
		bit in_range;
		n = active_len();
		if (first) begin
			partial_vec = '0;
			region_offset = '0;
			match_reported = 1'b0;
		end
		pos = region_offset;
		in_range = pos < OffsetLimit;
		if (in_range)
			region_offset = pos + 32'd1;
		if (n == 0) begin
			partial_vec = '0;
			return;
		end
		accept = '0;
		for (int unsigned i = 0; i < n; i++)
			if (wild_cfg[i] || sig_byte_at(i) == b)
				accept[i] = 1'b1;
		partial_vec = ((partial_vec << 1) | 32'd1) & accept;
		if (!partial_vec[n - 1] || !in_range)
			return;
		if (first_only_cfg && match_reported)
			return;
		match_reported = 1'b1;
		expected_offsets.insert(expected_offsets.size(), pos - 32'(n - 1));
	endfunction

	task automatic cfg_write(int unsigned idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= wbps_pkg::CfgAddrWidth'(idx * 8);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			wbps_pkg::REG_PAT_LOW: sig_bytes_cfg[0] = value;
			wbps_pkg::REG_PAT_SECOND: sig_bytes_cfg[1] = value;
			wbps_pkg::REG_PAT_THIRD: sig_bytes_cfg[2] = value;
			wbps_pkg::REG_PAT_HIGH: sig_bytes_cfg[3] = value;
			wbps_pkg::REG_WILDCARD: wild_cfg = value[31:0];
			wbps_pkg::REG_LENGTH: len_cfg = value[wbps_pkg::LenWidth-1:0];
			wbps_pkg::REG_MODE: first_only_cfg = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// upper bits of the narrow registers carry junk, the block must mask them
	task automatic load_signature(logic [3:0][63:0] pat, logic [31:0] wild,
			logic [wbps_pkg::LenWidth-1:0] len, logic mode);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		for (int i = 0; i < 4; i++)
			cfg_write(int'(wbps_pkg::REG_PAT_LOW) + i, pat[i]);
		cfg_write(wbps_pkg::REG_WILDCARD, {junk[63:32], wild});
		cfg_write(wbps_pkg::REG_LENGTH, {junk[63:wbps_pkg::LenWidth], len});
		cfg_write(wbps_pkg::REG_MODE, {junk[63:1], mode});
	endtask

	task automatic send_byte(logic [7:0] b, logic first);
		int r;
		int gap;
		@(negedge clk);
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.region_first <= first;
		// hold the word until the block takes it
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		scan_byte(b, first);
		if (sender_gaps) begin
			r = $urandom_range(0, 99);
			gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
			if (gap > 0) begin
				@(negedge clk);
				byte_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		for (int k = 0; k < 20000 && expected_offsets.size() > 0; k++)
			@(posedge clk);
		if (expected_offsets.size() > 0) begin
			note_mismatch("match never came", expected_offsets[0], 'x);
			mismatch_count += expected_offsets.size() - 1;
			expected_offsets.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// region of noise with the signature planted at random spots, some cut short
	task automatic send_region(int len, int plant_pct, bit start);
		int n;
		int pos;
		logic [7:0] b;
		n = active_len();
		pos = -1;
		for (int k = 0; k < len; k++) begin
			if (pos < 0 && n > 0 && $urandom_range(0, 99) < plant_pct)
				pos = 0;
			if (pos >= 0) begin
				b = wild_cfg[pos] ? 8'($urandom) : sig_byte_at(pos);
				pos = (pos + 1 >= n || $urandom_range(0, 49) == 0) ? -1 : pos + 1;
			end else if ($urandom_range(0, 1) || n == 0) begin
				b = 8'($urandom);
			end else begin
				b = sig_byte_at($urandom_range(0, n - 1));
			end
			send_byte(b, start && k == 0);
		end
	endtask

	// reset signature is one zero byte, and the stream starts with no region flag
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_directed_cases();
		logic [3:0][63:0] pat;
		pat = '0;
		pat[0][23:0] = 24'hCD_00_AB;
		wait_drain();
		load_signature(pat, 32'h0000_0002, 6'd3, 1'b0);
		send_byte(8'hAB, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hCD, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hCD, 1'b0);

		// overlapping matches, none across a region start
		pat[0][15:0] = 16'hFFFF;
		wait_drain();
		load_signature(pat, 32'h0, 6'd2, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);

		wait_drain();
		cfg_write(wbps_pkg::REG_MODE, 64'd1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);

		// empty signature, and a write past the last register
		wait_drain();
		cfg_write(wbps_pkg::REG_LENGTH, 64'd0);
		cfg_write(RegUnused, {$urandom, $urandom});
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
	endtask

	// every byte matches while the result side holds off, so the block backs up
	task automatic test_output_backpressure();
		logic [3:0][63:0] pat;
		pat = '0;
		wait_drain();
		load_signature(pat, 32'h1, 6'd1, 1'b0);
		sender_gaps = 1'b0;
		result_stalls = 1'b0;
		hold_request = 300;
		for (int k = 0; k < 80; k++)
			send_byte(8'($urandom), k == 0);
		wait_drain();
	endtask

	task automatic test_random_settings();
		logic [3:0][63:0] pat;
		logic [31:0] wild;
		logic [wbps_pkg::LenWidth-1:0] len;
		logic mode;
		bit narrow;
		int sent;
		int rlen;
		for (int p = 0; p < 9; p++) begin
			narrow = $urandom_range(0, 1);
			for (int i = 0; i < 32; i++)
				pat[i / 8][(i % 8) * 8 +: 8] = narrow ? 8'($urandom_range(8'h61, 8'h62))
					: 8'($urandom);
			wild = $urandom & $urandom;
			len = ($urandom_range(0, 4) == 0) ? 6'd32 : 6'($urandom_range(1, 8));
			mode = $urandom_range(0, 1);
			case (p)
				0: begin
					pat = '1;
					wild = '0;
					len = 6'd32;
					mode = 1'b0;
				end
				1: begin
					pat = '0;
					wild = '1;
					len = 6'd63;
					mode = 1'b1;
				end
				2: len = 6'd0;
				3: begin
					wild = '0;
					len = 6'd1;
					mode = 1'b0;
				end
				default: ;
			endcase
			sender_gaps = (p % 3 != 0);
			result_stalls = (p % 3 != 0);
			wait_drain();
			load_signature(pat, wild, len, mode);
			sent = 0;
			while (sent < 50) begin
				rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
					: $urandom_range(4, 40);
				send_region(rlen, 15, $urandom_range(0, 9) != 0);
				sent += rlen;
			end
		end
	endtask

	initial begin : result_sink
		int stall_left;
		int r;
		stall_left = 0;
		match_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				match_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (result_stalls && r < 15)
					stall_left = $urandom_range(1, 3);
				else if (result_stalls && r < 17)
					stall_left = $urandom_range(10, 40);
				match_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin : match_check
		logic [31:0] want;
		if (arst_n && match_ch.valid && match_ch.ready) begin
			if (expected_offsets.size() == 0) begin
				note_mismatch("unexpected match", 'x, match_ch.match_offset);
			end else begin
				want = expected_offsets.pop_front();
				if (match_ch.match_offset !== want)
					note_mismatch("match_offset", want, match_ch.match_offset);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.region_first = 1'b0;
		sig_bytes_cfg = '0;
		wild_cfg = '0;
		len_cfg = 6'd1;
		first_only_cfg = 1'b0;
		partial_vec = '0;
		region_offset = '0;
		match_reported = 1'b0;
		sender_gaps = 1'b1;
		result_stalls = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_cases();
		test_output_backpressure();
		test_random_settings();

		wait_drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
hdl/wbps_pkg.sv
hdl/wbps_byte_if.sv
hdl/wbps_match_if.sv
hdl/wbps_cfg.sv
hdl/wbps_scan.sv
hdl/wildcard_byte_pattern_scan.sv
bench/tb_wildcard_byte_pattern_scan.sv
